[rtl/assert_macros.svh]
// Assertion macros for the working-set tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WSWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define WSWT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/wswt_pkg.sv]
// Shared constants, types and helpers of the working-set tracker.
package wswt_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int PAGE_W     = 20;
  localparam int TIME_W     = 32;
  localparam int SIZE_W     = 5;

  localparam logic [SIZE_W-1:0] WIN_RESET = SIZE_W'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_EMIT
  } state_e;

  // Probe word that travels along the row of cells.
  typedef struct packed {
    logic              vld;
    logic [PAGE_W-1:0] page;
  } probe_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic shift;      // take a new reference, reload the probe row
    logic scan;       // move probes toward the newest end and compare
    logic load_emit;  // copy kept pages into the probe row
    logic emit_shift; // move probes toward the oldest end
  } cell_ctrl_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [MAX_WINDOW-1:0] bits);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sum = sum + CNT_W'(bits[i]);
    end
    return sum;
  endfunction

endpackage

[rtl/wswt_if.sv]
// Valid/ready channel interfaces for references and working-set members.
interface wswt_in_if;
  logic                        valid;
  logic                        ready;
  logic [wswt_pkg::PAGE_W-1:0] page;
  logic                        end_of_list;

  modport source (output valid, output page, output end_of_list, input ready);
  modport sink   (input valid, input page, input end_of_list, output ready);
endinterface

interface wswt_out_if;
  logic                        valid;
  logic                        ready;
  logic [wswt_pkg::TIME_W-1:0] time_index;
  logic [wswt_pkg::SIZE_W-1:0] set_size;
  logic [wswt_pkg::PAGE_W-1:0] member_page;
  logic                        last;

  modport source (output valid, output time_index, output set_size, output member_page,
                  output last, input ready);
  modport sink   (input valid, input time_index, input set_size, input member_page,
                  input last, output ready);
endinterface

[rtl/wswt_cell.sv]
// One cell of the window row: a stored page, a travelling probe and a duplicate flag.
module wswt_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wswt_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        in_win_i,
  input  logic [wswt_pkg::PAGE_W-1:0] prev_page_i,
  input  wswt_pkg::probe_t            up_probe_i,
  input  wswt_pkg::probe_t            dn_probe_i,
  output logic [wswt_pkg::PAGE_W-1:0] page_o,
  output wswt_pkg::probe_t            probe_o,
  output logic                        keep_o
);

  logic [wswt_pkg::PAGE_W-1:0] page_q;
  logic [wswt_pkg::PAGE_W-1:0] pg_q, pg_d;
  logic                        pv_q, pv_d;
  logic                        dup_q, dup_d;
  logic                        hit;

  assign hit    = up_probe_i.vld && (up_probe_i.page == page_q);
  assign keep_o = in_win_i && !dup_q;

  always_comb begin
    pg_d  = pg_q;
    pv_d  = pv_q;
    dup_d = dup_q;
    if (ctrl_i.shift) begin
      pg_d  = prev_page_i;
      pv_d  = in_win_i;
      dup_d = 1'b0;
    end else if (ctrl_i.scan) begin
      pg_d  = up_probe_i.page;
      pv_d  = up_probe_i.vld;
      dup_d = dup_q | hit;
    end else if (ctrl_i.load_emit) begin
      pg_d = page_q;
      pv_d = keep_o;
    end else if (ctrl_i.emit_shift) begin
      pg_d = dn_probe_i.page;
      pv_d = dn_probe_i.vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      dup_q <= 1'b0;
    end else begin
      pv_q  <= pv_d;
      dup_q <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q <= pg_d;
    if (ctrl_i.shift) begin
      page_q <= prev_page_i;
    end
  end

  assign page_o        = page_q;
  assign probe_o.vld   = pv_q;
  assign probe_o.page  = pg_q;

endmodule

[rtl/working_set_window_tracker_unit.sv]
// Top level of the working-set sliding-window tracker.
//
//  channel   dir  handshake     payload
//  --------  ---  ------------  ----------------------------------------------
//  in_i      in   valid/ready   page[19:0], end_of_list
//  out_o     out  valid/ready   time_index[31:0], set_size[4:0], member_page[19:0], last
//  cfg       in   cfg_we_i      cfg_wdata_i[4:0] = window_size (reset 4)
//
// A reference that does not fill the window only shifts the cell row. One that fills it
// goes through the accept step, the scan steps while probes pass along the cell row,
// the count step, and the emit walk along the row, which ends on the last kept member.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output holds the emit walk; the next reference is taken once the last
// member sits in the output register.
`include "assert_macros.svh"

module working_set_window_tracker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wswt_pkg::SIZE_W-1:0] cfg_wdata_i,
  wswt_in_if.sink                     in_i,
  wswt_out_if.source                  out_o
);

  localparam int MW = wswt_pkg::MAX_WINDOW;

  wswt_pkg::state_e            state_q, state_d;
  logic [wswt_pkg::SIZE_W-1:0] win_size_q;
  logic [wswt_pkg::CNT_W-1:0]  fill_q, fill_d, fill_inc;
  logic [wswt_pkg::TIME_W-1:0] ref_q, ref_d;
  logic                        eol_q;
  logic [wswt_pkg::IDX_W-1:0]  step_q, step_d;
  logic [wswt_pkg::CNT_W-1:0]  count_q, count_d;
  logic [wswt_pkg::CNT_W-1:0]  sent_q, sent_d;

  logic                        out_vld_q;
  logic [wswt_pkg::TIME_W-1:0] out_time_q;
  logic [wswt_pkg::SIZE_W-1:0] out_size_q;
  logic [wswt_pkg::PAGE_W-1:0] out_page_q;
  logic                        out_last_q;

  logic [wswt_pkg::CNT_W-1:0]  w_eff;
  logic [wswt_pkg::CNT_W-1:0]  w_less;
  logic [wswt_pkg::IDX_W-1:0]  head_idx;
  logic [MW-1:0]               win_mask;
  logic [MW-1:0]               keep;
  logic [MW-1:0]               pv_vec;
  wswt_pkg::cell_ctrl_t        cell_ctrl;
  wswt_pkg::probe_t            head;
  wswt_pkg::probe_t            cell_probe [MW];
  logic [wswt_pkg::PAGE_W-1:0] cell_page  [MW];

  logic in_accept;
  logic emit_now;
  logic out_free;
  logic out_load;
  logic out_last;

  // Clamp the window size to 1..MAX_WINDOW.
  always_comb begin
    if (win_size_q == '0) begin
      w_eff = wswt_pkg::CNT_W'(1);
    end else if (wswt_pkg::CNT_W'(win_size_q) > wswt_pkg::CNT_W'(MW)) begin
      w_eff = wswt_pkg::CNT_W'(MW);
    end else begin
      w_eff = wswt_pkg::CNT_W'(win_size_q);
    end
  end

  assign w_less   = w_eff - wswt_pkg::CNT_W'(1);
  assign head_idx = w_less[wswt_pkg::IDX_W-1:0];
  assign fill_inc = (fill_q < wswt_pkg::CNT_W'(MW)) ? fill_q + wswt_pkg::CNT_W'(1) : fill_q;

  assign in_i.ready = (state_q == wswt_pkg::ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign emit_now   = (fill_inc >= w_eff);

  // Oldest unsent member sits at the window's far end during the emit walk.
  assign head     = cell_probe[head_idx];
  assign out_free = !out_vld_q || out_o.ready;
  assign out_last = ((sent_q + wswt_pkg::CNT_W'(1)) == count_q);

  // Row of cells: pages shift toward the oldest end on each reference; probes
  // move toward the newest end while scanning and back while emitting.
  for (genvar i = 0; i < MW; i++) begin : g_cell
    wswt_pkg::probe_t            up_probe;
    wswt_pkg::probe_t            dn_probe;
    logic [wswt_pkg::PAGE_W-1:0] prev_page;

    assign win_mask[i] = (wswt_pkg::CNT_W'(i) < w_eff);
    assign pv_vec[i]   = cell_probe[i].vld;

    if (i == 0) begin : g_first
      assign prev_page = in_i.page;
      assign dn_probe  = '0;
    end else begin : g_inner
      assign prev_page = cell_page[i-1];
      assign dn_probe  = cell_probe[i-1];
    end

    if (i == MW - 1) begin : g_last
      assign up_probe = '0;
    end else begin : g_body
      assign up_probe = cell_probe[i+1];
    end

    wswt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .in_win_i    (win_mask[i]),
      .prev_page_i (prev_page),
      .up_probe_i  (up_probe),
      .dn_probe_i  (dn_probe),
      .page_o      (cell_page[i]),
      .probe_o     (cell_probe[i]),
      .keep_o      (keep[i])
    );
  end

  // Sequencer: accept a reference and, on a full window, scan for duplicates, count, then walk out the members.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ref_d     = ref_q;
    step_d    = step_q;
    count_d   = count_q;
    sent_d    = sent_q;
    cell_ctrl = '0;
    out_load  = 1'b0;
    unique case (state_q)
      wswt_pkg::ST_IDLE: begin
        if (in_accept) begin
          cell_ctrl.shift = 1'b1;
          if (emit_now) begin
            fill_d  = fill_inc;
            step_d  = head_idx;
            state_d = (head_idx == '0) ? wswt_pkg::ST_COUNT : wswt_pkg::ST_SCAN;
          end else if (in_i.end_of_list) begin
            // Drop the list: the fill count hides the stale pages.
            fill_d = '0;
            ref_d  = '0;
          end else begin
            fill_d = fill_inc;
            ref_d  = ref_q + wswt_pkg::TIME_W'(1);
          end
        end
      end
      wswt_pkg::ST_SCAN: begin
        cell_ctrl.scan = 1'b1;
        step_d         = step_q - wswt_pkg::IDX_W'(1);
        if (step_q == wswt_pkg::IDX_W'(1)) begin
          state_d = wswt_pkg::ST_COUNT;
        end
      end
      wswt_pkg::ST_COUNT: begin
        cell_ctrl.load_emit = 1'b1;
        count_d             = wswt_pkg::popcount(keep);
        sent_d              = '0;
        state_d             = wswt_pkg::ST_EMIT;
      end
      wswt_pkg::ST_EMIT: begin
        if (!head.vld) begin
          // Skip a repeated page.
          cell_ctrl.emit_shift = 1'b1;
        end else if (out_free) begin
          out_load             = 1'b1;
          cell_ctrl.emit_shift = 1'b1;
          sent_d               = sent_q + wswt_pkg::CNT_W'(1);
          if (out_last) begin
            state_d = wswt_pkg::ST_IDLE;
            if (eol_q) begin
              fill_d = '0;
              ref_d  = '0;
            end else begin
              ref_d = ref_q + wswt_pkg::TIME_W'(1);
            end
          end
        end
      end
      default: state_d = wswt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wswt_pkg::ST_IDLE;
      win_size_q <= wswt_pkg::WIN_RESET;
      fill_q     <= '0;
      ref_q      <= '0;
      eol_q      <= 1'b0;
      step_q     <= '0;
      count_q    <= '0;
      sent_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ref_q   <= ref_d;
      step_q  <= step_d;
      count_q <= count_d;
      sent_q  <= sent_d;
      if (cfg_we_i) begin
        win_size_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        eol_q <= in_i.end_of_list;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_time_q <= ref_q;
      out_size_q <= wswt_pkg::SIZE_W'(count_q);
      out_page_q <= head.page;
      out_last_q <= out_last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.time_index  = out_time_q;
  assign out_o.set_size    = out_size_q;
  assign out_o.member_page = out_page_q;
  assign out_o.last        = out_last_q;

  // The emit walk only runs on a full window.
  `WSWT_NEVER(a_emit_full, (state_q == wswt_pkg::ST_EMIT) && (fill_q < w_eff), "emit on partial window")
  // The set size stays within the window.
  `WSWT_ASSERT(a_count_range, (state_q == wswt_pkg::ST_EMIT) |-> ((count_q != '0) && (count_q <= w_eff)), "set size out of range")
  // Members still pending in the probe row match the beats still owed.
  `WSWT_ASSERT(a_pending, (state_q == wswt_pkg::ST_EMIT) |-> ($countones(pv_vec & win_mask) == int'(count_q - sent_q)), "pending member mismatch")

endmodule
